// ===== rtl/led_fade_blink_controller_defines.svh =====
// ----------------------------------------------------------------------------
// LED fade/blink controller - assertion macros
// Shared property wrappers for the controller's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LED_FADE_BLINK_CONTROLLER_DEFINES_SVH
`define LED_FADE_BLINK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LFBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lfbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define LFBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lfbc: next-cycle check failed");

`endif

// ===== rtl/lfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfbc_pkg
// Types and constants of the LED fade/blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbc_pkg;

    localparam int LFBC_LED_COUNT = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
    localparam int DIV_STEPS      = 16;

    // command codes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_RESET  = 3'd1;
    localparam logic [2:0] MODE_BRIGHT = 3'd2;
    localparam logic [2:0] MODE_BLINK  = 3'd3;
    localparam logic [2:0] MODE_DIM    = 3'd4;
    localparam logic [2:0] MODE_TIMER  = 3'd5;

    localparam logic [8:0] DUTY_FULL = 9'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DIVWB,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic timer;
        logic dim;
        logic blink;
    } t_fx_flags;

    // one LED's state, one memory word
    typedef struct packed {
        logic [7:0]  brightness;
        logic [7:0]  last_sent;
        logic [7:0]  ramp_level;
        logic [7:0]  ramp_target;
        logic [7:0]  ramp_mag;      // step magnitude; direction follows level vs target
        logic [15:0] ramp_reload;
        logic [15:0] ramp_count;
        logic [15:0] blink_count;
        logic [15:0] blink_period;
        logic [15:0] blink_on;
        logic [15:0] timeout_left;
        t_fx_flags   flags;
    } t_led_state;

endpackage

`default_nettype wire

// ===== rtl/led_fade_blink_controller.sv =====
// ----------------------------------------------------------------------------
// led_fade_blink_controller
// Per-LED effect engine: brightness, blink, dimming ramp and auto-off timer.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one command transaction:
//    tick, reset LED, set brightness, blink, dim ramp or off-timer.
//  - Output channel (o_out_valid / i_out_ready) carries duty updates; o_last
//    marks the final update caused by a transaction.
//  - Per-LED state sits in one memory word per LED, read and written back
//    through one read and one write port by a small sequencer, one LED at a time.
//  - Sequence: a command is accepted, its LED entry read, then updated; set
//    brightness adds a finish state to post its update. A dim ramp adds the
//    bit-serial divider state plus a write-back state. A tick reads and
//    updates each LED in turn over the memory port, then finishes.
//  - Throughput: one transaction at a time; o_in_ready is high only when idle.
//  - Reset clears the sequencer, output register and per-LED valid bits; an
//    LED entry never written reads as all zero, so no clearing pass is needed.
//  - A stalled receiver holds the output register; the walk then pauses at
//    the next LED that needs a new result to be posted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_fade_blink_controller_defines.svh"

module led_fade_blink_controller
    import lfbc_pkg::*;
#(
    parameter int LED_COUNT = LFBC_LED_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [2:0]  i_led,
    input  wire logic [7:0]  i_level,
    input  wire logic [8:0]  i_blink_duty,
    input  wire logic [15:0] i_ticks,
    // duty update channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_out_led,
    output logic [7:0]       o_duty,
    output logic             o_last
);

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // ---------------------------------------------------------------- state
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [2:0]        r_mode;
    logic [7:0]        r_level;
    logic [8:0]        r_bduty;
    logic [15:0]       r_ticks;
    logic [CNT_W-1:0]  r_n;

    // per-LED memory, valid bits stand in for the all-zero reset
    t_led_state        mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_vld;
    t_led_state        r_rd;
    logic              r_rd_vld;
    t_led_state        rd_eff;

    // held result: posted once the next one (or end of transaction) is known
    logic              r_held_v;
    logic [2:0]        r_held_led;
    logic [7:0]        r_held_duty;

    // output register
    logic              r_out_valid;
    logic [2:0]        r_out_led;
    logic [7:0]        r_out_duty;
    logic              r_out_last;

    // bit-serial divider
    logic [16:0]       r_rem;
    logic [15:0]       r_quo;
    logic [15:0]       r_div;
    logic [3:0]        r_cnt;
    logic              r_small;

    // ------------------------------------------------------ combinational
    logic              in_acc;
    logic              out_free;
    logic              cmd_ok;
    logic [IDX_W+2:0]  led_ext;
    logic [IDX_W+2:0]  idx_ext;
    logic [2:0]        idx3;
    logic              last_idx;

    t_led_state        t_next;
    logic              t_emit;
    logic              t_go;

    logic              mem_we;
    t_led_state        wr_data;
    logic              rd_en;
    logic              push;
    logic [2:0]        push_led;
    logic [7:0]        push_duty;
    logic              push_last;
    logic              held_load;
    logic [2:0]        held_led_d;
    logic [7:0]        held_duty_d;
    logic              held_clr;
    logic              div_load;
    logic [15:0]       div_num;
    logic [15:0]       div_den;
    logic              div_small;

    logic [16:0]       rem_sh;
    logic [16:0]       rem_sub;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign led_ext  = {{IDX_W{1'b0}}, i_led};
    assign idx_ext  = {3'b000, r_idx};
    assign idx3     = idx_ext[2:0];
    assign last_idx = (r_idx == IDX_W'(LED_COUNT - 1));
    // tick ignores the LED field
    assign cmd_ok   = (i_mode == MODE_TICK) ||
                      ((i_mode <= MODE_TIMER) && (32'(i_led) < LED_COUNT));
    assign rd_eff   = r_rd_vld ? r_rd : '0;

    // one LED's tick update on the entry just read
    always_comb begin : tick_calc
        t_led_state s;
        logic [8:0] sum;
        s = rd_eff;
        sum = '0;
        if (s.flags.timer) begin
            s.timeout_left = s.timeout_left - 16'd1;
            if (s.timeout_left == 16'd0) begin
                s.flags      = '0;
                s.brightness = '0;
            end
        end
        if (s.flags.dim && !s.flags.blink) begin
            if (s.ramp_level != s.ramp_target) begin
                s.ramp_count = s.ramp_count - 16'd1;
                if (s.ramp_count == 16'd0) begin
                    s.ramp_count = s.ramp_reload;
                    if (s.ramp_level < s.ramp_target) begin
                        sum = {1'b0, s.ramp_level} + {1'b0, s.ramp_mag};
                        s.ramp_level = (sum >= {1'b0, s.ramp_target}) ?
                                       s.ramp_target : sum[7:0];
                    end else begin
                        sum = {1'b0, s.ramp_target} + {1'b0, s.ramp_mag};
                        s.ramp_level = ({1'b0, s.ramp_level} < sum) ?
                                       s.ramp_target : (s.ramp_level - s.ramp_mag);
                    end
                    s.brightness = s.ramp_level;
                end
            end
        end else if (s.flags.blink && !s.flags.dim) begin
            s.blink_count = s.blink_count - 16'd1;
            if (s.blink_count == 16'd0) begin
                s.blink_count = s.blink_period;
            end
            s.brightness = (s.blink_count < s.blink_on) ? s.ramp_level : 8'd0;
        end
        t_emit = (s.brightness != s.last_sent) && (r_n != CNT_W'(MAX_RESULTS));
        if (t_emit) begin
            s.last_sent = s.brightness;
        end
        t_next = s;
    end

    // a new result may only displace the held one when the output is free
    assign t_go = !(t_emit && r_held_v) || out_free;

    // divider step
    assign rem_sh  = {r_rem[15:0], r_quo[15]};
    assign rem_sub = rem_sh - {1'b0, r_div};

    // ------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && cmd_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_mode)
                    MODE_TICK: begin
                        if (t_go) begin
                            n_state = last_idx ? S_FINISH : S_READ;
                        end
                    end
                    MODE_BRIGHT: n_state = S_FINISH;
                    MODE_DIM:    n_state = S_DIV;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (r_cnt == 4'(DIV_STEPS - 1)) begin
                    n_state = S_DIVWB;
                end
            end
            S_DIVWB: begin
                n_state = S_IDLE;
            end
            S_FINISH: begin
                if (!r_held_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------ FSM outputs
    always_comb begin : fsm_out
        logic [7:0]  cur;
        logic [7:0]  mag;
        logic [15:0] len;
        logic [8:0]  bd;
        logic [24:0] prod;
        mem_we      = 1'b0;
        wr_data     = rd_eff;
        rd_en       = 1'b0;
        push        = 1'b0;
        push_led    = r_held_led;
        push_duty   = r_held_duty;
        push_last   = 1'b0;
        held_load   = 1'b0;
        held_led_d  = idx3;
        held_duty_d = t_next.brightness;
        held_clr    = 1'b0;
        div_load    = 1'b0;
        div_num     = '0;
        div_den     = '0;
        div_small   = 1'b0;
        cur  = rd_eff.ramp_level;
        mag  = (r_level > cur) ? (r_level - cur) : (cur - r_level);
        len  = (r_ticks == 16'd0) ? 16'd1 : r_ticks;
        bd   = (r_bduty > DUTY_FULL) ? DUTY_FULL : r_bduty;
        prod = 25'(bd) * 25'(r_ticks);
        unique case (r_state)
            S_READ: begin
                rd_en = 1'b1;
            end
            S_EXEC: begin
                unique case (r_mode)
                    MODE_TICK: begin
                        if (t_go) begin
                            mem_we  = 1'b1;
                            wr_data = t_next;
                            if (t_emit) begin
                                held_load = 1'b1;
                                push      = r_held_v;
                            end
                        end
                    end
                    MODE_RESET: begin
                        mem_we            = 1'b1;
                        wr_data           = '0;
                        wr_data.last_sent = rd_eff.last_sent;
                    end
                    MODE_BRIGHT: begin
                        mem_we              = 1'b1;
                        wr_data.brightness  = r_level;
                        wr_data.ramp_level  = r_level;
                        wr_data.ramp_target = r_level;
                        held_load           = 1'b1;
                        held_duty_d         = r_level;
                    end
                    MODE_BLINK: begin
                        mem_we               = 1'b1;
                        wr_data.blink_count  = r_ticks;
                        wr_data.blink_period = r_ticks;
                        wr_data.blink_on     = prod[23:8];
                        wr_data.flags.blink  = 1'b1;
                        wr_data.flags.dim    = 1'b0;
                    end
                    MODE_DIM: begin
                        div_load  = 1'b1;
                        div_small = ({8'd0, mag} < len);
                        div_num   = div_small ? len : {8'd0, mag};
                        div_den   = div_small ? ((mag == 8'd0) ? 16'd1 : {8'd0, mag}) : len;
                    end
                    MODE_TIMER: begin
                        mem_we               = 1'b1;
                        wr_data.flags.timer  = 1'b1;
                        wr_data.timeout_left = r_ticks;
                    end
                    default: ;
                endcase
            end
            S_DIVWB: begin
                mem_we              = 1'b1;
                wr_data.ramp_mag    = r_small ? 8'd1 : r_quo[7:0];
                wr_data.ramp_reload = r_small ? r_quo : 16'd1;
                wr_data.ramp_count  = r_small ? r_quo : 16'd1;
                wr_data.ramp_target = r_level;
                wr_data.flags.dim   = 1'b1;
                wr_data.flags.blink = 1'b0;
            end
            S_FINISH: begin
                if (r_held_v && out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    held_clr  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // ------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_held_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_n         <= '0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (held_load) begin
                r_held_v <= 1'b1;
            end else if (held_clr) begin
                r_held_v <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_n <= '0;
            end else if (held_load) begin
                r_n <= r_n + CNT_W'(1);
            end
        end
    end

    // transaction fields and walk index
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_level <= i_level;
            r_bduty <= i_blink_duty;
            r_ticks <= i_ticks;
            r_idx   <= (i_mode == MODE_TICK) ? '0 : led_ext[IDX_W-1:0];
        end else if (r_state == S_EXEC && r_mode == MODE_TICK && t_go && !last_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // LED state memory: one read, one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd     <= mem[r_idx];
            r_rd_vld <= r_vld[r_idx];
        end
    end

    // held result and output register payload
    always_ff @(posedge i_clk) begin
        if (held_load) begin
            r_held_led  <= held_led_d;
            r_held_duty <= held_duty_d;
        end
        if (push) begin
            r_out_led  <= push_led;
            r_out_duty <= push_duty;
            r_out_last <= push_last;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_rem   <= '0;
            r_quo   <= div_num;
            r_div   <= div_den;
            r_cnt   <= '0;
            r_small <= div_small;
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt + 4'd1;
            if (!rem_sub[16]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_led   = r_out_led;
    assign o_duty      = r_out_duty;
    assign o_last      = r_out_last;

    // ------------------------------------------------------ assertions
    `LFBC_ASSERT_IMP(a_idle_nothing_held, i_clk, i_rst_n, o_in_ready, !r_held_v)
    `LFBC_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_div != 16'd0)
    `LFBC_ASSERT_IMP(a_we_states, i_clk, i_rst_n, mem_we, r_state == S_EXEC || r_state == S_DIVWB)
    `LFBC_ASSERT_NXT(a_push_sets_valid, i_clk, i_rst_n, push, r_out_valid)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - LED fade/blink controller testbench
// Feeds command transactions from a queue through a bursty driver, predicts
// every duty update with a behavioral copy of the per-LED state, and checks
// each update taken from the output channel in order. The receiver stalls on
// its own pattern, including one long hold-off that backs up the block.
// ----------------------------------------------------------------------------

module tb_top
    import lfbc_pkg::*;
();

    localparam int LED_N       = 8;
    localparam int ITEM_TARGET = 450;
    localparam int QUIET_LIMIT = 3000;   // cycles with no transaction on either side
    localparam int HOLD_AT     = 220;    // commands accepted before the long hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;     // covers a full tick walk plus slack
    localparam int MAX_SHOWN   = 10;

    // modes the block must ignore
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  led;
        logic [7:0]  level;
        logic [8:0]  duty;
        logic [15:0] ticks;
    } t_cmd;

    typedef struct packed {
        logic [2:0] led;
        logic [7:0] duty;
        logic       last;
    } t_duty_upd;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_style;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_mode;
    logic [2:0]  i_led;
    logic [7:0]  i_level;
    logic [8:0]  i_blink_duty;
    logic [15:0] i_ticks;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_out_led;
    logic [7:0]  o_duty;
    logic        o_last;

    led_fade_blink_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_led        (i_led),
        .i_level      (i_level),
        .i_blink_duty (i_blink_duty),
        .i_ticks      (i_ticks),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_led    (o_out_led),
        .o_duty       (o_duty),
        .o_last       (o_last)
    );

    // ------------------------------------------------------------------------
    // Predicted per-LED state
    // ------------------------------------------------------------------------
    logic [7:0]  bright_r  [LED_N];
    logic [7:0]  sent_r    [LED_N];   // duty last posted by a tick
    logic [7:0]  lvl_r     [LED_N];
    logic [7:0]  tgt_r     [LED_N];
    logic [7:0]  mag_r     [LED_N];   // ramp step magnitude
    logic [15:0] reload_r  [LED_N];
    logic [15:0] rcount_r  [LED_N];
    logic [15:0] bcount_r  [LED_N];
    logic [15:0] bperiod_r [LED_N];
    logic [15:0] bon_r     [LED_N];
    logic [15:0] tmo_r     [LED_N];
    t_fx_flags   fx_r      [LED_N];

    t_cmd        pending_cmds [$];
    t_duty_upd   exp_duty_q   [$];

    int          cmds_queued;
    int          cmds_accepted;
    int          fail_count;
    int          quiet_cycles;

    // driver and receiver bookkeeping
    t_cmd        cur_cmd;
    int          burst_left;
    int          gap_left;
    int          seg_left;
    int          hold_left;
    bit          hold_done;
    int          rx_phase;
    t_rx_style   rx_style;
    logic        rx_rdy;
    t_duty_upd   want;

    // Works out the duty updates one accepted command causes and queues them.
    function automatic void predict_duty_updates(input t_cmd c);
        int unsigned i, k, n_out, cur, len, dmag, smag, rl, lv, tg, d;
        bit          up;
        logic [2:0]  upd_led  [MAX_RESULTS];
        logic [7:0]  upd_duty [MAX_RESULTS];
        t_duty_upd   u;
        n_out = 0;
        case (c.mode)
            MODE_TICK: begin
                for (i = 0; i < LED_N; i++) begin
                    if (fx_r[i].timer) begin
                        tmo_r[i] = tmo_r[i] - 16'd1;
                        if (tmo_r[i] == 16'd0) begin
                            fx_r[i]     = '0;
                            bright_r[i] = 8'd0;
                        end
                    end
                    if (fx_r[i].dim && !fx_r[i].blink) begin
                        if (lvl_r[i] != tgt_r[i]) begin
                            rcount_r[i] = rcount_r[i] - 16'd1;
                            if (rcount_r[i] == 16'd0) begin
                                rcount_r[i] = reload_r[i];
                                lv = lvl_r[i];
                                tg = tgt_r[i];
                                // step toward the target, never past it
                                if (lv < tg)
                                    lv = (lv + mag_r[i] >= tg) ? tg : lv + mag_r[i];
                                else
                                    lv = (lv < tg + mag_r[i]) ? tg : lv - mag_r[i];
                                lvl_r[i]    = lv[7:0];
                                bright_r[i] = lv[7:0];
                            end
                        end
                    end else if (fx_r[i].blink && !fx_r[i].dim) begin
                        bcount_r[i] = bcount_r[i] - 16'd1;
                        if (bcount_r[i] == 16'd0)
                            bcount_r[i] = bperiod_r[i];
                        bright_r[i] = (bcount_r[i] < bon_r[i]) ? lvl_r[i] : 8'd0;
                    end
                    if (bright_r[i] != sent_r[i] && n_out < MAX_RESULTS) begin
                        upd_led[n_out]  = i[2:0];
                        upd_duty[n_out] = bright_r[i];
                        sent_r[i]       = bright_r[i];
                        n_out++;
                    end
                end
            end
            MODE_RESET: begin
                bright_r[c.led]  = '0;
                lvl_r[c.led]     = '0;
                tgt_r[c.led]     = '0;
                mag_r[c.led]     = '0;
                reload_r[c.led]  = '0;
                rcount_r[c.led]  = '0;
                bcount_r[c.led]  = '0;
                bperiod_r[c.led] = '0;
                bon_r[c.led]     = '0;
                tmo_r[c.led]     = '0;
                fx_r[c.led]      = '0;
            end
            MODE_BRIGHT: begin
                bright_r[c.led] = c.level;
                lvl_r[c.led]    = c.level;
                tgt_r[c.led]    = c.level;
                upd_led[0]      = c.led;
                upd_duty[0]     = c.level;
                n_out           = 1;
            end
            MODE_BLINK: begin
                d = (c.duty > DUTY_FULL) ? DUTY_FULL : c.duty;
                bcount_r[c.led]  = c.ticks;
                bperiod_r[c.led] = c.ticks;
                rl = (d * c.ticks) >> 8;
                bon_r[c.led]     = rl[15:0];
                fx_r[c.led].blink = 1'b1;
                fx_r[c.led].dim   = 1'b0;
            end
            MODE_DIM: begin
                cur  = lvl_r[c.led];
                len  = (c.ticks == 16'd0) ? 1 : c.ticks;
                up   = c.level > cur;
                dmag = up ? c.level - cur : cur - c.level;
                if (dmag < len) begin
                    smag = 1;
                    rl   = (dmag != 0) ? len / dmag : len;
                end else begin
                    smag = dmag / len;
                    rl   = 1;
                end
                mag_r[c.led]    = smag[7:0];
                reload_r[c.led] = rl[15:0];
                rcount_r[c.led] = rl[15:0];
                tgt_r[c.led]    = c.level;
                fx_r[c.led].dim   = 1'b1;
                fx_r[c.led].blink = 1'b0;
            end
            MODE_TIMER: begin
                fx_r[c.led].timer = 1'b1;
                tmo_r[c.led]      = c.ticks;
            end
            default: ;  // unused modes do nothing
        endcase
        for (k = 0; k < n_out; k++) begin
            u.led  = upd_led[k];
            u.duty = upd_duty[k];
            u.last = (k == n_out - 1);
            exp_duty_q.push_back(u);
        end
    endfunction

    task automatic queue_cmd(input logic [2:0] mode, input int led, input int level,
                             input int duty, input int ticks);
        t_cmd c;
        c.mode  = mode;
        c.led   = led[2:0];
        c.level = level[7:0];
        c.duty  = duty[8:0];
        c.ticks = ticks[15:0];
        pending_cmds.push_back(c);
        if (mode <= MODE_TIMER)
            cmds_queued++;
    endtask

    // tick fields are don't-care, so they carry random noise
    task automatic queue_ticks(input int n);
        int k;
        for (k = 0; k < n; k++)
            queue_cmd(MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                      $urandom_range(0, 511), $urandom_range(0, 65535));
    endtask

    // mostly short durations so effects play out; now and then any 16-bit value
    function automatic int pick_ticks();
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(0, 12);
    endfunction

    function automatic int pick_duty();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return DUTY_FULL;
            2:       return $urandom_range(257, 511);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int i, ln;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_TICK;
        i_led        = '0;
        i_level      = '0;
        i_blink_duty = '0;
        i_ticks      = '0;
        i_out_ready  = 1'b0;
        cmds_queued   = 0;
        cmds_accepted = 0;
        fail_count    = 0;
        for (i = 0; i < LED_N; i++) begin
            bright_r[i] = '0;  sent_r[i]    = '0;  lvl_r[i]    = '0;
            tgt_r[i]    = '0;  mag_r[i]     = '0;  reload_r[i] = '0;
            rcount_r[i] = '0;  bcount_r[i]  = '0;  bperiod_r[i] = '0;
            bon_r[i]    = '0;  tmo_r[i]     = '0;  fx_r[i]     = '0;
        end

        // directed: field extremes, every mode, saturated duty, zero period,
        // zero ramp duration, flat ramp, timer wrap and ignored modes
        queue_cmd(MODE_BRIGHT, 0, 255, 0, 0);
        queue_cmd(MODE_BRIGHT, 7, 0, 511, 65535);
        queue_cmd(MODE_BRIGHT, 1, 200, 0, 0);
        queue_cmd(MODE_BLINK,  1, 0, 128, 4);
        queue_cmd(MODE_BRIGHT, 2, 77, 0, 0);
        queue_cmd(MODE_BLINK,  2, 255, 511, 0);
        queue_cmd(MODE_DIM,    3, 255, 0, 0);
        queue_cmd(MODE_DIM,    4, 10, 0, 65535);
        queue_cmd(MODE_DIM,    5, 0, 0, 3);
        queue_cmd(MODE_BRIGHT, 6, 50, 0, 0);
        queue_cmd(MODE_TIMER,  6, 0, 0, 2);
        queue_cmd(MODE_TIMER,  0, 0, 0, 0);
        queue_ticks(3);
        queue_cmd(MODE_RESET,  1, 255, 511, 65535);
        queue_cmd(MODE_DIM,    0, 0, 0, 1);
        queue_cmd(MODE_RSVD6,  3, 255, 511, 65535);
        queue_cmd(MODE_RSVD7,  4, 0, 0, 0);
        queue_ticks(1);
        queue_cmd(MODE_BRIGHT, 4, 255, 256, 65535);
        queue_cmd(MODE_BLINK,  5, 170, 256, 2);
        queue_ticks(2);

        // random: mostly short effect sequences followed by ticks, plus noise
        while (cmds_queued < ITEM_TARGET) begin
            ln = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0, 1: begin
                    queue_cmd(MODE_BRIGHT, ln, $urandom_range(0, 255), pick_duty(),
                              pick_ticks());
                    queue_cmd(MODE_BLINK, ln, $urandom_range(0, 255), pick_duty(),
                              $urandom_range(0, 8));
                    queue_ticks($urandom_range(2, 10));
                end
                2, 3, 4: begin
                    queue_cmd(MODE_DIM, ln, $urandom_range(0, 255), pick_duty(),
                              pick_ticks());
                    queue_ticks($urandom_range(2, 12));
                end
                5: begin
                    queue_cmd(MODE_TIMER, ln, $urandom_range(0, 255), pick_duty(),
                              $urandom_range(0, 6));
                    queue_ticks($urandom_range(1, 8));
                end
                6: begin
                    queue_cmd(MODE_DIM, ln, $urandom_range(0, 255), pick_duty(),
                              $urandom_range(0, 6));
                    queue_cmd(MODE_TIMER, ln, $urandom_range(0, 255), pick_duty(),
                              pick_ticks());
                    queue_ticks($urandom_range(2, 8));
                end
                7: begin
                    queue_cmd(MODE_RESET, ln, $urandom_range(0, 255), pick_duty(),
                              pick_ticks());
                    queue_ticks(1);
                end
                default: begin
                    queue_cmd(3'($urandom_range(0, 7)), ln, $urandom_range(0, 255),
                              $urandom_range(0, 511), $urandom_range(0, 65535));
                end
            endcase
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(cmds_accepted == pending_cmds.size() + cmds_accepted && !i_in_valid
                 && exp_duty_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (exp_duty_q.size() != 0) begin
            $display("missing %0d duty update(s) at end of run", exp_duty_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Command driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_duty_updates(cur_cmd);
                cmds_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 || pending_cmds.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    cur_cmd = pending_cmds.pop_front();
                    i_in_valid   <= 1'b1;
                    i_mode       <= cur_cmd.mode;
                    i_led        <= cur_cmd.led;
                    i_level      <= cur_cmd.level;
                    i_blink_duty <= cur_cmd.duty;
                    i_ticks      <= cur_cmd.ticks;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: segments of varying stall style, one long hold-off mid-run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            seg_left  = 0;
            hold_left = 0;
            hold_done = 1'b0;
            rx_phase  = 0;
            rx_style  = RX_ALWAYS;
        end else begin
            if (!hold_done && cmds_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_rdy = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    rx_style = t_rx_style'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                rx_phase++;
                case (rx_style)
                    RX_ALWAYS: rx_rdy = 1'b1;
                    RX_COIN:   rx_rdy = $urandom_range(0, 1);
                    RX_SPARSE: rx_rdy = ($urandom_range(0, 3) == 0);
                    default:   rx_rdy = (rx_phase % 5) < 2;
                endcase
            end
            i_out_ready <= rx_rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each duty update against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_duty_q.size() == 0) begin
                if (fail_count < MAX_SHOWN)
                    $display("unexpected duty update: led=%0d duty=%0d last=%0b",
                             o_out_led, o_duty, o_last);
                fail_count++;
            end else begin
                want = exp_duty_q.pop_front();
                if (o_out_led !== want.led || o_duty !== want.duty
                    || o_last !== want.last) begin
                    if (fail_count < MAX_SHOWN)
                        $display("duty mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.led, want.duty, want.last, o_out_led, o_duty,
                                 o_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: any transaction on either channel resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
